// ----- rtl/core/fbms_pkg.sv -----
`timescale 1ns / 1ps

package fbms_pkg;

    // datapath widths
    localparam int WORD_W    = 32;
    localparam int CNT_W     = $clog2(WORD_W + 1);
    localparam int MS_W      = 10;
    localparam int COEFF_W   = 16;
    localparam int OPCODE_W  = 2;
    localparam int CFG_IDX_W = 8;

    // command codes
    localparam logic [OPCODE_W-1:0] OP_STEP  = OPCODE_W'(0);
    localparam logic [OPCODE_W-1:0] OP_STOP  = OPCODE_W'(1);
    localparam logic [OPCODE_W-1:0] OP_CLEAR = OPCODE_W'(2);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRICTION_COEFF = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_MASS      = CFG_IDX_W'(1);

    // reset value of the body mass, 1.0 in Q16.16
    localparam logic [WORD_W-1:0] MASS_RESET = WORD_W'(65536);

    // milliseconds per second, divisor of every time scaling
    localparam logic [WORD_W-1:0] MS_PER_S = WORD_W'(1000);

    // sequencer phases of one time step
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_GM,
        ST_FRIC,
        ST_FMUL,
        ST_FDIV,
        ST_AMUL,
        ST_ADIV,
        ST_PMUL,
        ST_PDIV,
        ST_DONE
    } fsm_state_t;

    // magnitude of a signed word, the most negative value maps to 2^31
    function automatic logic [WORD_W-1:0] mag_word(input logic [WORD_W-1:0] v);
        mag_word = v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
    endfunction

    // base plus or minus an unsigned magnitude, saturated to a signed word
    function automatic logic [WORD_W-1:0] add_sat(input logic [WORD_W-1:0] base,
                                                  input logic [WORD_W-1:0] mag,
                                                  input logic neg);
        logic [WORD_W+1:0] b_ext;
        logic [WORD_W+1:0] m_ext;
        logic [WORD_W+1:0] sum;
        b_ext = {{2{base[WORD_W-1]}}, base};
        m_ext = {2'b00, mag};
        sum   = neg ? (b_ext - m_ext) : (b_ext + m_ext);
        if (sum[WORD_W+1:WORD_W-1] == 3'b000 || sum[WORD_W+1:WORD_W-1] == 3'b111) begin
            add_sat = sum[WORD_W-1:0];
        end else if (sum[WORD_W+1]) begin
            add_sat = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            add_sat = {1'b0, {(WORD_W-1){1'b1}}};
        end
    endfunction

endpackage

// ----- rtl/core/friction_body_motion_step_core.sv -----
// Friction body motion step core. Each s_ transaction is one command (time step, stop, or
// clear) and yields exactly one m_ transaction carrying the new position and velocity in
// signed Q16.16. A time step runs through nine phases on bit-serial units (two 32-bit
// shift-add multipliers, two 32-bit restoring dividers and one square root unit), each
// phase launching its units on entry; the result then enters the output register once
// that register is free. Stop, clear and the unused opcode skip the phases and go straight
// to that load. The serial word width of these units sets the step latency.
// One command is worked on at a time; a finished result waits in the output register and
// s_ready returns as soon as it is loaded. friction_coeff (index 0) and body_mass
// (index 1) are written through the cfg_ port, which is always ready; write them only
// while no command is outstanding. Other indexes are ignored.
`timescale 1ns / 1ps

module friction_body_motion_step_core import fbms_pkg::*; #(
    parameter logic [WORD_W-1:0] GRAVITY_Q16 = 32'd642908
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [OPCODE_W-1:0]         s_opcode,
    input  logic [MS_W-1:0]             s_elapsed_ms,
    input  logic signed [WORD_W-1:0]    s_field_x,
    input  logic signed [WORD_W-1:0]    s_field_y,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [WORD_W-1:0]    m_position_x,
    output logic signed [WORD_W-1:0]    m_position_y,
    output logic signed [WORD_W-1:0]    m_velocity_x,
    output logic signed [WORD_W-1:0]    m_velocity_y,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [WORD_W-1:0]           cfg_data
);

    fsm_state_t state_reg, state_next;
    logic       launch_reg, launch_next;
    logic       load_out;
    logic       s_fire;

    // configuration
    logic [COEFF_W-1:0] coeff_reg;
    logic [WORD_W-1:0]  mass_reg;

    // body state
    logic [WORD_W-1:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;

    // per-step working registers
    logic [WORD_W-1:0]   fx_reg, fy_reg;
    logic [MS_W-1:0]     ms_reg;
    logic                moving_reg;
    logic [2*WORD_W-1:0] sq_reg;
    logic [WORD_W-1:0]   speed_reg;
    logic [WORD_W-2:0]   gm_reg;
    logic [WORD_W-2:0]   fric_reg;
    logic [WORD_W-1:0]   ax_reg, ay_reg;

    // output register
    logic              m_valid_reg;
    logic [WORD_W-1:0] m_pos_x_reg, m_pos_y_reg, m_vel_x_reg, m_vel_y_reg;

    // unit hookup
    logic                mul_start, div_start, sqrt_start;
    logic [WORD_W-1:0]   mul0_a, mul0_b, mul1_a, mul1_b;
    logic                mul0_done, mul1_done;
    logic [2*WORD_W-1:0] mul0_prod, mul1_prod;
    logic [WORD_W-1:0]   div_divisor;
    logic                div0_done, div1_done;
    logic [WORD_W-1:0]   div0_quot, div1_quot;
    logic                sqrt_done;
    logic [WORD_W-1:0]   sqrt_root;

    // step arithmetic
    logic [WORD_W-2:0] gm_sat, fric_sat;
    logic [WORD_W-1:0] ax_val, ay_val, nvx_raw, nvy_raw, px_val, py_val;
    logic              xdir, ydir, nx_pos, ny_pos, flip;

    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
        end
    end

    // sequencer next state; each phase launches its units on entry
    always_comb begin
        state_next  = state_reg;
        launch_next = 1'b0;
        load_out    = 1'b0;
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_opcode == OP_STEP) begin
                        state_next  = ST_SQ;
                        launch_next = 1'b1;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SQ: begin
                if (mul0_done) begin
                    state_next  = ST_GM;
                    launch_next = 1'b1;
                end
            end
            ST_GM: begin
                if (mul0_done) begin
                    state_next  = ST_FRIC;
                    launch_next = 1'b1;
                end
            end
            ST_FRIC: begin
                if (mul0_done) begin
                    state_next  = ST_FMUL;
                    launch_next = 1'b1;
                end
            end
            ST_FMUL: begin
                if (mul0_done) begin
                    state_next  = ST_FDIV;
                    launch_next = 1'b1;
                end
            end
            ST_FDIV: begin
                if (div0_done) begin
                    state_next  = ST_AMUL;
                    launch_next = 1'b1;
                end
            end
            ST_AMUL: begin
                if (mul0_done) begin
                    state_next  = ST_ADIV;
                    launch_next = 1'b1;
                end
            end
            ST_ADIV: begin
                if (div0_done) begin
                    state_next  = ST_PMUL;
                    launch_next = 1'b1;
                end
            end
            ST_PMUL: begin
                if (mul0_done) begin
                    state_next  = ST_PDIV;
                    launch_next = 1'b1;
                end
            end
            ST_PDIV: begin
                if (div0_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // unit starts
    assign mul_start  = launch_reg && (state_reg == ST_SQ || state_reg == ST_GM ||
                        state_reg == ST_FRIC || state_reg == ST_FMUL ||
                        state_reg == ST_AMUL || state_reg == ST_PMUL);
    assign div_start  = launch_reg && (state_reg == ST_FDIV || state_reg == ST_ADIV ||
                        state_reg == ST_PDIV);
    assign sqrt_start = launch_reg && (state_reg == ST_GM);

    // multiplier operands per phase, lane 0 is x and lane 1 is y
    always_comb begin
        mul0_a = '0;
        mul0_b = '0;
        mul1_a = '0;
        mul1_b = '0;
        case (state_reg)
            ST_SQ: begin
                mul0_a = mag_word(vel_x_reg);
                mul0_b = mag_word(vel_x_reg);
                mul1_a = mag_word(vel_y_reg);
                mul1_b = mag_word(vel_y_reg);
            end
            ST_GM: begin
                mul0_a = GRAVITY_Q16;
                mul0_b = mass_reg;
            end
            ST_FRIC: begin
                mul0_a = WORD_W'(gm_reg);
                mul0_b = WORD_W'(coeff_reg);
            end
            ST_FMUL: begin
                mul0_a = WORD_W'(fric_reg);
                mul0_b = mag_word(vel_x_reg);
                mul1_a = WORD_W'(fric_reg);
                mul1_b = mag_word(vel_y_reg);
            end
            ST_AMUL: begin
                mul0_a = mag_word(ax_reg);
                mul0_b = WORD_W'(ms_reg);
                mul1_a = mag_word(ay_reg);
                mul1_b = WORD_W'(ms_reg);
            end
            ST_PMUL: begin
                mul0_a = mag_word(vel_x_reg);
                mul0_b = WORD_W'(ms_reg);
                mul1_a = mag_word(vel_y_reg);
                mul1_b = WORD_W'(ms_reg);
            end
            default: begin
                mul0_a = '0;
            end
        endcase
    end

    // friction divides by speed, time scaling by milliseconds per second
    assign div_divisor = (state_reg == ST_FDIV) ? speed_reg : MS_PER_S;

    fbms_ser_mul u_mul0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul0_a),
        .b       (mul0_b),
        .done    (mul0_done),
        .prod    (mul0_prod)
    );

    fbms_ser_mul u_mul1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul1_a),
        .b       (mul1_b),
        .done    (mul1_done),
        .prod    (mul1_prod)
    );

    fbms_ser_div u_div0 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mul0_prod),
        .divisor  (div_divisor),
        .done     (div0_done),
        .quot     (div0_quot)
    );

    fbms_ser_div u_div1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mul1_prod),
        .divisor  (div_divisor),
        .done     (div1_done),
        .quot     (div1_quot)
    );

    fbms_ser_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sq_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // saturating shifts of the friction products
    assign gm_sat   = (mul0_prod[2*WORD_W-1:47] != '0) ? {(WORD_W-1){1'b1}}
                                                        : mul0_prod[46:16];
    assign fric_sat = (mul0_prod[2*WORD_W-1:43] != '0) ? {(WORD_W-1){1'b1}}
                                                        : mul0_prod[42:12];

    // friction acts against each velocity component
    assign ax_val = add_sat(fx_reg, div0_quot, !vel_x_reg[WORD_W-1]);
    assign ay_val = add_sat(fy_reg, div1_quot, !vel_y_reg[WORD_W-1]);

    // velocity update and direction flip test
    assign nvx_raw = add_sat(vel_x_reg, div0_quot, ax_reg[WORD_W-1]);
    assign nvy_raw = add_sat(vel_y_reg, div1_quot, ay_reg[WORD_W-1]);
    assign xdir    = !vel_x_reg[WORD_W-1] && (vel_x_reg != '0);
    assign ydir    = !vel_y_reg[WORD_W-1] && (vel_y_reg != '0);
    assign nx_pos  = !nvx_raw[WORD_W-1] && (nvx_raw != '0);
    assign ny_pos  = !nvy_raw[WORD_W-1] && (nvy_raw != '0);
    assign flip    = moving_reg && (xdir != nx_pos) && (ydir != ny_pos);

    // position update with the new velocity
    assign px_val = add_sat(pos_x_reg, div0_quot, vel_x_reg[WORD_W-1]);
    assign py_val = add_sat(pos_y_reg, div1_quot, vel_y_reg[WORD_W-1]);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg <= '0;
            mass_reg  <= MASS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FRICTION_COEFF: coeff_reg <= cfg_data[COEFF_W-1:0];
                CFG_BODY_MASS:      mass_reg  <= cfg_data;
                default:            coeff_reg <= coeff_reg;
            endcase
        end
    end

    // position and velocity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            vel_x_reg <= '0;
            vel_y_reg <= '0;
        end else begin
            if (s_fire) begin
                case (s_opcode)
                    OP_STOP: begin
                        vel_x_reg <= '0;
                        vel_y_reg <= '0;
                    end
                    OP_CLEAR: begin
                        pos_x_reg <= '0;
                        pos_y_reg <= '0;
                        vel_x_reg <= '0;
                        vel_y_reg <= '0;
                    end
                    default: begin
                        vel_x_reg <= vel_x_reg;
                    end
                endcase
            end
            if (state_reg == ST_ADIV && div0_done) begin
                vel_x_reg <= flip ? '0 : nvx_raw;
                vel_y_reg <= flip ? '0 : nvy_raw;
            end
            if (state_reg == ST_PDIV && div0_done) begin
                pos_x_reg <= px_val;
                pos_y_reg <= py_val;
            end
        end
    end

    // per-step working values captured on acceptance and at phase ends
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            fx_reg     <= s_field_x;
            fy_reg     <= s_field_y;
            ms_reg     <= s_elapsed_ms;
            moving_reg <= (vel_x_reg != '0) || (vel_y_reg != '0);
        end
        if (state_reg == ST_SQ && mul0_done) begin
            sq_reg <= mul0_prod + mul1_prod;
        end
        if (state_reg == ST_GM && mul0_done) begin
            speed_reg <= (sqrt_root == '0) ? WORD_W'(1) : sqrt_root;
            gm_reg    <= gm_sat;
        end
        if (state_reg == ST_FRIC && mul0_done) begin
            fric_reg <= moving_reg ? fric_sat : '0;
        end
        if (state_reg == ST_FDIV && div0_done) begin
            ax_reg <= ax_val;
            ay_reg <= ay_val;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_pos_x_reg <= pos_x_reg;
            m_pos_y_reg <= pos_y_reg;
            m_vel_x_reg <= vel_x_reg;
            m_vel_y_reg <= vel_y_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_position_x = m_pos_x_reg;
    assign m_position_y = m_pos_y_reg;
    assign m_velocity_x = m_vel_x_reg;
    assign m_velocity_y = m_vel_y_reg;

    // both lanes run in lockstep
    a_lanes_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul0_done == mul1_done) && (div0_done == div1_done))
        else $error("x and y lanes out of step");

    // the root is ready in the same cycle as the gravity-mass product
    a_sqrt_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GM && mul0_done) |-> sqrt_done)
        else $error("square root not aligned with its phase");

    // every quotient fits one word
    a_div_range: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (mul0_prod[2*WORD_W-1:WORD_W] < div_divisor) &&
                      (mul1_prod[2*WORD_W-1:WORD_W] < div_divisor))
        else $error("divider quotient overflow");

    // one command in flight
    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("command accepted while busy");

    // a finished result reaches the output register and frees the input
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_ready)) |=> (m_valid && s_ready))
        else $error("result not loaded");

endmodule

// ----- rtl/core/fbms_ser_mul.sv -----
`timescale 1ns / 1ps

module fbms_ser_mul import fbms_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [WORD_W-1:0]     a,
    input  logic [WORD_W-1:0]     b,
    output logic                  done,
    output logic [2*WORD_W-1:0]   prod
);

    logic [2*WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0]   mcand_reg, mcand_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [WORD_W:0]     sum;

    // shift-add: one multiplier bit per cycle, lsb first
    always_comb begin
        sum        = {1'b0, acc_reg[2*WORD_W-1:WORD_W]}
                   + (acc_reg[0] ? {1'b0, mcand_reg} : {(WORD_W+1){1'b0}});
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (start) begin
            acc_next   = {{WORD_W{1'b0}}, b};
            mcand_next = a;
            cnt_next   = CNT_W'(WORD_W);
        end else if (cnt_reg != '0) begin
            acc_next  = {sum, acc_reg[WORD_W-1:1]};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // operands and partial product
    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- rtl/core/fbms_ser_div.sv -----
`timescale 1ns / 1ps

// quotient must fit one word: the upper half of the dividend is below the divisor
module fbms_ser_div import fbms_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [2*WORD_W-1:0]   dividend,
    input  logic [WORD_W-1:0]     divisor,
    output logic                  done,
    output logic [WORD_W-1:0]     quot
);

    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W+1:0] diff;
    logic              ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial     = {rem_reg, quo_reg[WORD_W-1]};
        diff      = {1'b0, trial} - {2'b00, dsr_reg};
        ge        = !diff[WORD_W+1];
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = dividend[2*WORD_W-1:WORD_W];
            quo_next = dividend[WORD_W-1:0];
            dsr_next = divisor;
            cnt_next = CNT_W'(WORD_W);
        end else if (cnt_reg != '0) begin
            rem_next  = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            quo_next  = {quo_reg[WORD_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // remainder, dividend / quotient shift register, divisor
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ----- rtl/core/fbms_ser_sqrt.sv -----
`timescale 1ns / 1ps

module fbms_ser_sqrt import fbms_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [2*WORD_W-1:0]   radicand,
    output logic                  done,
    output logic [WORD_W-1:0]     root
);

    logic [2*WORD_W-1:0] rad_reg, rad_next;
    logic [WORD_W+1:0]   rem_reg, rem_next;
    logic [WORD_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [WORD_W+3:0]   t;
    logic [WORD_W+3:0]   trial;
    logic [WORD_W+4:0]   diff;
    logic                ge;

    // digit-by-digit root: two radicand bits in, one root bit out per cycle
    always_comb begin
        t         = {rem_reg, rad_reg[2*WORD_W-1:2*WORD_W-2]};
        trial     = {2'b00, root_reg, 2'b01};
        diff      = {1'b0, t} - {1'b0, trial};
        ge        = !diff[WORD_W+4];
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(WORD_W);
        end else if (cnt_reg != '0) begin
            rad_next  = {rad_reg[2*WORD_W-3:0], 2'b00};
            rem_next  = ge ? diff[WORD_W+1:0] : t[WORD_W+1:0];
            root_next = {root_reg[WORD_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // radicand shift register, partial remainder and root
    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- test/motion_step_checker.sv -----
`timescale 1ns / 1ps

module motion_step_checker import fbms_pkg::*; #(
    parameter logic [WORD_W-1:0] GRAVITY_Q16 = 32'd642908
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [OPCODE_W-1:0]      s_opcode,
    input  logic [MS_W-1:0]          s_elapsed_ms,
    input  logic signed [WORD_W-1:0] s_field_x,
    input  logic signed [WORD_W-1:0] s_field_y,

    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [WORD_W-1:0] m_position_x,
    input  logic signed [WORD_W-1:0] m_position_y,
    input  logic signed [WORD_W-1:0] m_velocity_x,
    input  logic signed [WORD_W-1:0] m_velocity_y,

    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [WORD_W-1:0]        cfg_data,

    output int                       errors,
    output int                       pending
);

    localparam longint WORD_MAX   = 64'sh7FFF_FFFF;
    localparam longint WORD_MIN   = -64'sh8000_0000;
    localparam longint MS_PER_SEC = 1000;
    localparam longint unsigned FRIC_CAP = 64'h7FFF_FFFF;

    typedef struct packed {
        logic signed [WORD_W-1:0] px;
        logic signed [WORD_W-1:0] py;
        logic signed [WORD_W-1:0] vx;
        logic signed [WORD_W-1:0] vy;
    } body_state_t;

    // register copies and body state as the block should hold them
    logic [COEFF_W-1:0]       coeff_q;
    logic [WORD_W-1:0]        mass_q;
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] vel_x;
    logic signed [WORD_W-1:0] vel_y;

    body_state_t expected_states[$];

    task automatic report_mismatch(input string what);
        $display("%0t ns motion check: %s", $time, what);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %08h expected %08h", name, got, want));
        end
    endtask

    function automatic logic signed [WORD_W-1:0] clamp_word(input longint v);
        if (v > WORD_MAX) return 32'sh7FFF_FFFF;
        if (v < WORD_MIN) return 32'sh8000_0000;
        return v[WORD_W-1:0];
    endfunction

    function automatic longint unsigned word_mag(input logic signed [WORD_W-1:0] v);
        longint sv;
        sv = longint'(v);
        return (sv < 0) ? -sv : sv;
    endfunction

    // value times elapsed milliseconds over 1000, truncated toward zero
    function automatic longint scale_ms(input longint v, input logic [MS_W-1:0] ms);
        longint t;
        t = longint'(ms);
        return (v * t) / MS_PER_SEC;
    endfunction

    // friction share of one axis, opposing that velocity component
    function automatic longint friction_share(input logic signed [WORD_W-1:0] v,
                                              input longint unsigned fric,
                                              input longint unsigned speed);
        longint unsigned m;
        longint sm;
        m  = (fric * word_mag(v)) / speed;
        sm = m;
        if (v > 0) return -sm;
        if (v < 0) return sm;
        return 0;
    endfunction

    // advance the body by one command and queue the state it must report
    function automatic void advance_body(input logic [OPCODE_W-1:0] op,
                                         input logic [MS_W-1:0] ms,
                                         input logic signed [WORD_W-1:0] fx,
                                         input logic signed [WORD_W-1:0] fy);
        longint ax;
        longint ay;
        longint unsigned sq;
        longint unsigned root;
        longint unsigned probe;
        longint unsigned gm;
        longint unsigned fric;
        logic moving;
        logic x_pos;
        logic y_pos;
        logic signed [WORD_W-1:0] nvx;
        logic signed [WORD_W-1:0] nvy;
        ax = longint'(fx);
        ay = longint'(fy);
        case (op)
            OP_STEP: begin
                moving = (vel_x != 0) || (vel_y != 0);
                if (moving) begin
                    // floor square root of the squared speed
                    sq = word_mag(vel_x) * word_mag(vel_x) + word_mag(vel_y) * word_mag(vel_y);
                    root  = 0;
                    probe = 64'd1 << 62;
                    while (probe > sq) probe = probe >> 2;
                    while (probe != 0) begin
                        if (sq >= root + probe) begin
                            sq   = sq - (root + probe);
                            root = (root >> 1) + probe;
                        end else begin
                            root = root >> 1;
                        end
                        probe = probe >> 2;
                    end
                    if (root == 0) root = 1;
                    // kinetic friction magnitude
                    gm = 64'(GRAVITY_Q16);
                    gm = (gm * mass_q) >> 16;
                    if (gm > FRIC_CAP) gm = FRIC_CAP;
                    fric = (gm * coeff_q) >> 12;
                    if (fric > FRIC_CAP) fric = FRIC_CAP;
                    ax = longint'(clamp_word(ax + friction_share(vel_x, fric, root)));
                    ay = longint'(clamp_word(ay + friction_share(vel_y, fric, root)));
                end
                // velocity update, cleared when both directions flip
                x_pos = vel_x > 0;
                y_pos = vel_y > 0;
                nvx = clamp_word(longint'(vel_x) + scale_ms(ax, ms));
                nvy = clamp_word(longint'(vel_y) + scale_ms(ay, ms));
                if (moving && (x_pos != (nvx > 0)) && (y_pos != (nvy > 0))) begin
                    nvx = '0;
                    nvy = '0;
                end
                vel_x = nvx;
                vel_y = nvy;
                pos_x = clamp_word(longint'(pos_x) + scale_ms(longint'(vel_x), ms));
                pos_y = clamp_word(longint'(pos_y) + scale_ms(longint'(vel_y), ms));
            end
            OP_STOP: begin
                vel_x = '0;
                vel_y = '0;
            end
            OP_CLEAR: begin
                pos_x = '0;
                pos_y = '0;
                vel_x = '0;
                vel_y = '0;
            end
            default: begin
            end
        endcase
        expected_states.push_back('{pos_x, pos_y, vel_x, vel_y});
    endfunction

    // watch all three channels at the rising edge
    always @(posedge aclk) begin
        body_state_t want;
        if (!aresetn) begin
            coeff_q = '0;
            mass_q  = MASS_RESET;
            pos_x   = '0;
            pos_y   = '0;
            vel_x   = '0;
            vel_y   = '0;
            expected_states.delete();
        end else begin
            // result transaction against the oldest expected state
            if (m_valid && m_ready) begin
                if (expected_states.size() == 0) begin
                    report_mismatch($sformatf("unexpected result pos %08h %08h vel %08h %08h",
                                              m_position_x, m_position_y,
                                              m_velocity_x, m_velocity_y));
                end else begin
                    want = expected_states.pop_front();
                    compare_field("position_x", m_position_x, want.px);
                    compare_field("position_y", m_position_y, want.py);
                    compare_field("velocity_x", m_velocity_x, want.vx);
                    compare_field("velocity_y", m_velocity_y, want.vy);
                end
            end
            // register writes, unknown indexes are dropped
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FRICTION_COEFF: coeff_q = cfg_data[COEFF_W-1:0];
                    CFG_BODY_MASS:      mass_q  = cfg_data;
                    default: begin
                    end
                endcase
            end
            // command transaction
            if (s_valid && s_ready) begin
                advance_body(s_opcode, s_elapsed_ms, s_field_x, s_field_y);
            end
        end
        pending = expected_states.size();
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import fbms_pkg::*;

    localparam logic [WORD_W-1:0]    GRAVITY_Q16      = 32'd642908;
    localparam logic [OPCODE_W-1:0]  OP_UNUSED        = OPCODE_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX   = CFG_IDX_W'(255);
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 400;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASES       = 10;
    localparam int PLANNED      = 6;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                     s_valid      = 1'b0;
    logic                     s_ready;
    logic [OPCODE_W-1:0]      s_opcode     = OP_STEP;
    logic [MS_W-1:0]          s_elapsed_ms = '0;
    logic signed [WORD_W-1:0] s_field_x    = '0;
    logic signed [WORD_W-1:0] s_field_y    = '0;

    logic                     m_valid;
    logic                     m_ready      = 1'b0;
    logic signed [WORD_W-1:0] m_position_x;
    logic signed [WORD_W-1:0] m_position_y;
    logic signed [WORD_W-1:0] m_velocity_x;
    logic signed [WORD_W-1:0] m_velocity_y;

    logic                     cfg_valid    = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index    = '0;
    logic [WORD_W-1:0]        cfg_data     = '0;

    int   errors;
    int   pending;
    int   cycle_count = 0;
    logic s_took      = 1'b0;
    logic cfg_took    = 1'b0;
    int   rx_left     = 0;
    int   rx_stall    = 0;

    // register settings of the first phases, extremes among them
    logic [COEFF_W-1:0] coeff_plan [PLANNED] = '{16'd0, 16'hFFFF, 16'd4096,
                                                 16'd200, 16'hFFFF, 16'd0};
    logic [WORD_W-1:0]  mass_plan  [PLANNED] = '{32'd0, 32'hFFFF_FFFF, 32'h0001_0000,
                                                 32'h0000_8000, 32'd0, 32'hFFFF_FFFF};

    friction_body_motion_step_core #(
        .GRAVITY_Q16 (GRAVITY_Q16)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_elapsed_ms (s_elapsed_ms),
        .s_field_x    (s_field_x),
        .s_field_y    (s_field_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_position_x (m_position_x),
        .m_position_y (m_position_y),
        .m_velocity_x (m_velocity_x),
        .m_velocity_y (m_velocity_y),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    motion_step_checker #(
        .GRAVITY_Q16 (GRAVITY_Q16)
    ) checker_inst (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_elapsed_ms (s_elapsed_ms),
        .s_field_x    (s_field_x),
        .s_field_y    (s_field_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_position_x (m_position_x),
        .m_position_y (m_position_y),
        .m_velocity_x (m_velocity_x),
        .m_velocity_y (m_velocity_y),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("friction_body_motion_step_core verification failed");
            $finish;
        end
    end

    // handshakes seen at the rising edge, read back at the falling edge
    always @(posedge aclk) begin
        s_took   <= s_valid && s_ready;
        cfg_took <= cfg_valid && cfg_ready;
    end

    // result side: runs of random length, each with its own stall rate
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_left <= $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0:       rx_stall <= 0;
                1:       rx_stall <= 30;
                2:       rx_stall <= 70;
                default: rx_stall <= 100;
            endcase
        end else begin
            rx_left <= rx_left - 1;
        end
        m_ready <= ($urandom_range(0, 99) >= rx_stall);
    end

    // called at a falling edge; returns at the falling edge after the transaction
    // with valid still high, so the caller either sends again or drops valid
    task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [MS_W-1:0] ms,
                            input logic [WORD_W-1:0] fx, input logic [WORD_W-1:0] fy);
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_elapsed_ms <= ms;
        s_field_x    <= fx;
        s_field_y    <= fy;
        do @(negedge aclk); while (!s_took);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge aclk); while (!cfg_took);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge aclk);
    endtask

    // field value drawn from one of several magnitude classes
    function automatic logic [WORD_W-1:0] random_field();
        logic [WORD_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0:       return r;
            1:       return {{12{r[19]}}, r[19:0]};
            2:       return {{16{r[15]}}, r[15:0]};
            3:       return {{8{r[23]}}, r[23:0]};
            4:       return '0;
            default: return r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    initial begin
        int                  sent;
        int                  burst;
        int                  pick;
        logic [OPCODE_W-1:0] op;
        logic [MS_W-1:0]     ms;
        logic [COEFF_W-1:0]  coeff;
        logic [WORD_W-1:0]   mass;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // unit friction, unit mass, and a write to an unknown index
        write_reg(CFG_FRICTION_COEFF, 32'h0000_1000);
        write_reg(CFG_BODY_MASS, MASS_RESET);
        write_reg(CFG_FIRST_UNUSED, 32'hDEAD_BEEF);

        // directed: start from rest, then friction slows a moving body
        send_cmd(OP_STEP, 10'd1000, 32'h0001_0000, 32'h0000_0000);
        send_cmd(OP_STEP, 10'd100, 32'h0000_0000, 32'h0000_0000);
        send_cmd(OP_STOP, 10'd1023, 32'hFFFF_FFFF, 32'h8000_0000);
        // both components flip under friction and the velocity is cleared
        send_cmd(OP_STEP, 10'd1000, 32'h0001_0000, 32'h0001_0000);
        send_cmd(OP_STEP, 10'd500, 32'h0000_0000, 32'h0000_0000);
        send_cmd(OP_STEP, 10'd1000, 32'hFFFF_0000, 32'h0001_0000);
        send_cmd(OP_STEP, 10'd1000, 32'h0000_0000, 32'h0000_0000);
        send_cmd(OP_UNUSED, 10'd517, 32'h1234_5678, 32'h9ABC_DEF0);
        // saturation of velocity and position
        send_cmd(OP_STEP, 10'd1023, 32'h7FFF_FFFF, 32'h8000_0000);
        send_cmd(OP_STEP, 10'd1023, 32'h7FFF_FFFF, 32'h8000_0000);
        send_cmd(OP_STEP, 10'd1023, 32'h7FFF_FFFF, 32'h8000_0000);
        send_cmd(OP_STEP, 10'd0, 32'h5555_5555, 32'hAAAA_AAAA);
        send_cmd(OP_CLEAR, 10'd0, 32'h0000_0000, 32'h0000_0000);
        send_cmd(OP_STEP, 10'd1023, 32'h8000_0000, 32'h7FFF_FFFF);
        send_cmd(OP_STEP, 10'd1, 32'h0000_0001, 32'hFFFF_FFFF);
        send_cmd(OP_STEP, 10'd1023, 32'h8000_0000, 32'h8000_0000);
        send_cmd(OP_CLEAR, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(OP_STEP, 10'd682, 32'hAAAA_AAAA, 32'h5555_5555);
        send_cmd(OP_STEP, 10'd341, 32'h5555_5555, 32'hAAAA_AAAA);
        send_cmd(OP_UNUSED, 10'd0, 32'h0000_0000, 32'h0000_0000);
        send_cmd(OP_STOP, 10'd0, 32'h0000_0000, 32'h0000_0000);
        send_cmd(OP_STEP, 10'd1023, 32'h0000_0000, 32'h0000_0000);
        s_valid <= 1'b0;
        @(negedge aclk);
        wait_drained();

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < PLANNED) begin
                coeff = coeff_plan[ph];
                mass  = mass_plan[ph];
            end else begin
                coeff = COEFF_W'($urandom_range(0, 8192));
                mass  = $urandom_range(0, 32'h0004_0000);
            end
            write_reg(CFG_FRICTION_COEFF, {16'($urandom), coeff});
            write_reg(CFG_BODY_MASS, mass);
            write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_INDEX)), $urandom);

            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES) begin
                burst = $urandom_range(1, 16);
                repeat (burst) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 15) op = OP_STEP;
                    else if (pick < 17) op = OP_STOP;
                    else if (pick < 19) op = OP_CLEAR;
                    else op = OP_UNUSED;
                    if ($urandom_range(0, 1) == 0) ms = MS_W'($urandom_range(0, 1023));
                    else ms = MS_W'($urandom_range(0, 40));
                    send_cmd(op, ms, random_field(), random_field());
                    sent++;
                end
                s_valid <= 1'b0;
                @(negedge aclk);
                // now and then hold off until every result is back
                if ($urandom_range(0, 9) == 0) wait_drained();
                else repeat ($urandom_range(0, 12)) @(negedge aclk);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0) begin
            $display("friction_body_motion_step_core verification clean");
        end else begin
            $display("friction_body_motion_step_core verification failed");
        end
        $finish;
    end

endmodule
